/* rtl/core/hdfs_pkg.sv */
// ----------------------------------------------------------------------------
// hdfs_pkg
// Shared types, constants and the exp(-x) table for the Hawkes feature stream.
// ----------------------------------------------------------------------------
package hdfs_pkg;

  localparam int EXP_TABLE_BITS = 8;
  localparam int TIME_FRAC_BITS = 16;

  localparam int TAB_SIZE   = (1 << EXP_TABLE_BITS) + 1;
  localparam int TAB_IDX_W  = EXP_TABLE_BITS + 1;
  localparam int SEG_SHIFT  = 20 - EXP_TABLE_BITS;
  localparam int TAB_W      = 31;
  localparam int E_W        = TIME_FRAC_BITS + 1;
  localparam int PROD_W     = 48;
  localparam int MAC_W      = E_W + 33;
  localparam int SUM_W      = 40;
  localparam int HALF_SUM_W = SUM_W / 2;
  localparam int PART_W     = HALF_SUM_W + 16;
  localparam int INT_W      = SUM_W + 17;

  localparam logic [E_W-1:0] ONE_E = E_W'(1) << TIME_FRAC_BITS;

  typedef logic [TAB_W-1:0] tab_ent_t;
  typedef tab_ent_t [TAB_SIZE-1:0] exp_tab_t;

  typedef struct packed {
    logic [31:0] event_time;
    logic [31:0] window_end;
    logic        first_event;
    logic        last_event;
  } in_item_t;

  typedef struct packed {
    logic [31:0] excitation;
    logic        integral_valid;
    logic [31:0] integral;
    logic        sequence_end;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXC_MUL,
    ST_EXC_INT,
    ST_EXC_RND,
    ST_EXC_MAC,
    ST_TRM_MUL,
    ST_TRM_INT,
    ST_TRM_RND,
    ST_INT_LO,
    ST_INT_HI,
    ST_DONE
  } state_t;

  typedef enum logic {
    REG_DECAY_RATE = 1'b0,
    REG_INV_DECAY  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic cap;
    logic sel_term;
    logic mul_en;
    logic int_en;
    logic rnd_en;
    logic mac_en;
    logic acc_en;
    logic lo_en;
    logic hi_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // shift-subtract quotient, evaluated at elaboration only
  function automatic logic [63:0] const_quot(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] d;
    logic [63:0] mag;
    logic [63:0] acc;
    logic [63:0] p;
    d   = 64'd1 << (34 - EXP_TABLE_BITS);
    mag = 64'd1 << 30;
    acc = 64'd1 << 30;
    for (int k = 1; k <= 20; k++) begin
      mag = const_quot((mag * d) >> 30, 64'(k));
      if (k[0]) acc = acc - mag;
      else acc = acc + mag;
    end
    t[0] = TAB_W'(64'd1 << 30);
    for (int k = 1; k < TAB_SIZE; k++) begin
      p = (64'(t[k-1]) * acc + (64'd1 << 29)) >> 30;
      t[k] = p[TAB_W-1:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

/* rtl/core/hdfs_regs.sv */
// ----------------------------------------------------------------------------
// hdfs_regs
// APB-style register file: decay rate and its reciprocal.
// ----------------------------------------------------------------------------
module hdfs_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] decay_rate,
  output logic [15:0] inv_decay_rate
);

  logic [15:0] rate_r, rate_nxt;
  logic [15:0] inv_r, inv_nxt;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    rate_nxt = rate_r;
    inv_nxt  = inv_r;
    if (wr) begin
      unique case (hdfs_pkg::reg_idx_t'(paddr[2]))
        hdfs_pkg::REG_DECAY_RATE: rate_nxt = pwdata[15:0];
        hdfs_pkg::REG_INV_DECAY:  inv_nxt  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= 16'd4096;
      inv_r  <= 16'd256;
    end else begin
      rate_r <= rate_nxt;
      inv_r  <= inv_nxt;
    end
  end

  always_comb begin
    unique case (hdfs_pkg::reg_idx_t'(paddr[2]))
      hdfs_pkg::REG_DECAY_RATE: prdata = {16'd0, rate_r};
      hdfs_pkg::REG_INV_DECAY:  prdata = {16'd0, inv_r};
      default:                  prdata = 32'd0;
    endcase
  end

  assign decay_rate     = rate_r;
  assign inv_decay_rate = inv_r;

endmodule

/* rtl/core/hdfs_ctrl.sv */
// ----------------------------------------------------------------------------
// hdfs_ctrl
// Sequencer: steps one request through both decays, the sum and the scaling.
// ----------------------------------------------------------------------------
module hdfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hdfs_pkg::dp_stat_t  stat,
  output hdfs_pkg::dp_cmd_t   cmd
);

  hdfs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= hdfs_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      hdfs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = hdfs_pkg::ST_EXC_MUL;
        end
      end
      hdfs_pkg::ST_EXC_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = hdfs_pkg::ST_EXC_INT;
      end
      hdfs_pkg::ST_EXC_INT: begin
        cmd.int_en = 1'b1;
        state_nxt  = hdfs_pkg::ST_EXC_RND;
      end
      hdfs_pkg::ST_EXC_RND: begin
        cmd.rnd_en = 1'b1;
        state_nxt  = hdfs_pkg::ST_EXC_MAC;
      end
      hdfs_pkg::ST_EXC_MAC: begin
        cmd.mac_en = 1'b1;
        state_nxt  = hdfs_pkg::ST_TRM_MUL;
      end
      hdfs_pkg::ST_TRM_MUL: begin
        cmd.sel_term = 1'b1;
        cmd.mul_en   = 1'b1;
        state_nxt    = hdfs_pkg::ST_TRM_INT;
      end
      hdfs_pkg::ST_TRM_INT: begin
        cmd.int_en = 1'b1;
        state_nxt  = hdfs_pkg::ST_TRM_RND;
      end
      hdfs_pkg::ST_TRM_RND: begin
        cmd.rnd_en = 1'b1;
        state_nxt  = hdfs_pkg::ST_INT_LO;
      end
      hdfs_pkg::ST_INT_LO: begin
        cmd.acc_en = 1'b1;
        state_nxt  = hdfs_pkg::ST_INT_HI;
      end
      hdfs_pkg::ST_INT_HI: begin
        cmd.lo_en = 1'b1;
        cmd.hi_en = 1'b1;
        state_nxt = hdfs_pkg::ST_DONE;
      end
      hdfs_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = hdfs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hdfs_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/hdfs_dp.sv */
// ----------------------------------------------------------------------------
// hdfs_dp
// Datapath: shared exp(-x) unit, excitation recurrence, integral sum, output.
// ----------------------------------------------------------------------------
module hdfs_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hdfs_pkg::in_item_t   in_data,
  input  logic [15:0]          decay_rate,
  input  logic [15:0]          inv_decay_rate,
  input  hdfs_pkg::dp_cmd_t    cmd,
  output hdfs_pkg::dp_stat_t   stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hdfs_pkg::out_item_t  out_data
);

  localparam int F  = hdfs_pkg::TIME_FRAC_BITS;
  localparam int S  = hdfs_pkg::SEG_SHIFT;
  localparam int TW = hdfs_pkg::TAB_W;
  localparam int EW = hdfs_pkg::E_W;
  localparam int PW = hdfs_pkg::PROD_W;
  localparam int MW = hdfs_pkg::MAC_W;
  localparam int SW = hdfs_pkg::SUM_W;
  localparam int HW = hdfs_pkg::HALF_SUM_W;
  localparam int QW = hdfs_pkg::PART_W;
  localparam int IW = hdfs_pkg::INT_W;
  localparam int IX = hdfs_pkg::TAB_IDX_W;

  hdfs_pkg::in_item_t item_r;
  logic [31:0]     prev_time_r, prev_exc_r, exc_r;
  logic [SW-1:0]   sum_r;
  logic [PW-1:0]   prod_r;
  logic [TW-1:0]   a_r;
  logic [TW+S-1:0] m_r;
  logic            zero_r;
  logic [EW-1:0]   e_r;
  logic [QW-1:0]   plo_r, phi_r;
  logic            out_valid_r;
  hdfs_pkg::out_item_t out_r;

  logic [31:0]     delta;
  logic [19:0]     x;
  logic [IX-1:0]   idx0, idx1;
  logic [S-1:0]    rem;
  logic [TW-1:0]   ta, tb;
  logic [TW-1:0]   e_q30;
  logic [TW:0]     e_rnd;
  logic [32:0]     one_plus;
  logic [MW-1:0]   mac;
  logic [MW-1:0]   mac_rnd;
  logic [31:0]     exc_nxt;
  logic [SW-1:0]   sum_base;
  logic [SW:0]     sum_add;
  logic [IW-1:0]   integ_full;
  logic [31:0]     integ;

  always_comb begin
    if (cmd.sel_term)
      delta = (item_r.window_end >= item_r.event_time) ?
              item_r.window_end - item_r.event_time : 32'd0;
    else
      delta = (item_r.event_time >= prev_time_r) ?
              item_r.event_time - prev_time_r : 32'd0;
  end

  assign x     = prod_r[F+15:F-4];
  assign idx0  = {1'b0, x[19:S]};
  assign idx1  = idx0 + IX'(1);
  assign rem   = x[S-1:0];
  assign ta    = hdfs_pkg::EXP_TAB[idx0];
  assign tb    = hdfs_pkg::EXP_TAB[idx1];

  assign e_q30 = a_r - TW'(m_r >> S);
  assign e_rnd = {1'b0, e_q30} + ((TW+1)'(1) << (29 - F));

  assign one_plus = 33'(hdfs_pkg::ONE_E) + {1'b0, prev_exc_r};
  assign mac      = MW'(e_r) * MW'(one_plus);
  assign mac_rnd  = (mac + (MW'(1) << (F - 1))) >> F;
  assign exc_nxt  = item_r.first_event ? 32'd0 :
                    (|mac_rnd[MW-1:32]) ? 32'hFFFF_FFFF : mac_rnd[31:0];

  assign sum_base = item_r.first_event ? '0 : sum_r;
  assign sum_add  = {1'b0, sum_base} + (SW+1)'(hdfs_pkg::ONE_E - e_r);

  assign integ_full = (IW'({phi_r, {HW{1'b0}}}) + IW'(plo_r) + IW'(128)) >> 8;
  assign integ      = !item_r.last_event ? 32'd0 :
                      (|integ_full[IW-1:32]) ? 32'hFFFF_FFFF : integ_full[31:0];

  always_ff @(posedge clk) begin
    if (cmd.cap) item_r <= in_data;
    if (cmd.mul_en) prod_r <= PW'(delta) * PW'(decay_rate);
    if (cmd.int_en) begin
      zero_r <= |prod_r[PW-1:F+16];
      a_r    <= ta;
      m_r    <= (TW+S)'(ta - tb) * (TW+S)'(rem);
    end
    if (cmd.rnd_en) e_r <= zero_r ? '0 : e_rnd[TW-1:30-F];
    if (cmd.mac_en) exc_r <= exc_nxt;
    if (cmd.lo_en) plo_r <= QW'(sum_r[HW-1:0]) * QW'(inv_decay_rate);
    if (cmd.hi_en) phi_r <= QW'(sum_r[SW-1:HW]) * QW'(inv_decay_rate);
    if (cmd.out_load) begin
      out_r.excitation     <= exc_r;
      out_r.integral_valid <= item_r.last_event;
      out_r.integral       <= integ;
      out_r.sequence_end   <= item_r.last_event;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r <= '0;
      prev_exc_r  <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mac_en) begin
        prev_time_r <= item_r.event_time;
        prev_exc_r  <= exc_nxt;
      end
      if (cmd.acc_en)
        sum_r <= sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

/* rtl/core/hawkes_decay_feature_stream_top.sv */
// ----------------------------------------------------------------------------
// hawkes_decay_feature_stream_top
// Hawkes exponential-kernel excitation and compensator features per event.
// ----------------------------------------------------------------------------
// Events are taken one at a time: the sequencer runs the one shared exp(-x)
// unit twice (excitation, then integral term) before the sum update and the
// two-part 1/beta scaling, and takes no new event until the result has been
// loaded into the output register. A new event is taken while the previous
// result still waits in the output register. Write decay_rate (0x0) and
// inv_decay_rate (0x4) only between requests.
module hawkes_decay_feature_stream_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hdfs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hdfs_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  hdfs_pkg::dp_cmd_t  cmd;
  hdfs_pkg::dp_stat_t stat;
  logic [15:0]        decay_rate, inv_decay_rate;

  hdfs_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .decay_rate(decay_rate), .inv_decay_rate(inv_decay_rate)
  );

  hdfs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  hdfs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .decay_rate(decay_rate),
    .inv_decay_rate(inv_decay_rate), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

/* tb/hdfs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdfs_checker
// Watches both channels and the register port of the Hawkes feature stream,
// predicts each event's features and compares them with the results.
// ----------------------------------------------------------------------------
module hdfs_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  hdfs_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  hdfs_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending
);
  import hdfs_pkg::*;

  localparam int F = 16;
  localparam int NT = 257;

  logic [31:0] dec_tab [NT];
  logic [15:0] beta_q;
  logic [15:0] inv_beta_q;
  logic [31:0] last_t;
  logic [31:0] last_exc;
  logic [39:0] run_sum;
  out_item_t   feat_q[$];

  initial begin
    logic [63:0] d, mag, acc;
    d = 64'd1 << 26;
    mag = 64'd1 << 30;
    acc = 64'd1 << 30;
    for (int k = 1; k <= 20; k++) begin
      mag = ((mag * d) >> 30) / k;
      if (k % 2) acc = acc - mag;
      else acc = acc + mag;
    end
    dec_tab[0] = 32'd1 << 30;
    for (int k = 1; k < NT; k++)
      dec_tab[k] = 32'(((64'(dec_tab[k-1]) * acc) + (64'd1 << 29)) >> 30);
  end

  function automatic logic [63:0] exp_neg(logic [31:0] delta, logic [15:0] b);
    logic [63:0] x, i, r, a, bb, e;
    x = (64'(delta) * 64'(b)) >> 12;
    if (x >= (64'd16 << 16)) return 0;
    i = x >> 12;
    r = x & 64'hFFF;
    a = dec_tab[i];
    bb = dec_tab[i+1];
    e = a - (((a - bb) * r) >> 12);
    return (e + (64'd1 << 13)) >> 14;
  endfunction

  assign pending = feat_q.size();

  always @(posedge clk) begin
    logic [63:0] e, exc, trm, s, ig;
    out_item_t   exp_r;
    if (!rst_n) begin
      beta_q <= 16'd4096;
      inv_beta_q <= 16'd256;
      last_t <= 0;
      last_exc <= 0;
      run_sum <= 0;
      fail_count <= 0;
      feat_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == (3'(REG_DECAY_RATE) << 2)) beta_q <= pwdata[15:0];
        else if (paddr == (3'(REG_INV_DECAY) << 2)) inv_beta_q <= pwdata[15:0];
      end
      if (in_valid && in_ready) begin
        s = run_sum;
        if (in_data.first_event) begin
          exc = 0;
          s = 0;
        end else begin
          e = exp_neg(in_data.event_time >= last_t ? in_data.event_time - last_t : 0,
                      beta_q);
          exc = (e * ((64'd1 << F) + 64'(last_exc)) + (64'd1 << (F-1))) >> F;
          if (exc > 64'hFFFFFFFF) exc = 64'hFFFFFFFF;
        end
        trm = (64'd1 << F) - exp_neg(in_data.window_end >= in_data.event_time ?
                                     in_data.window_end - in_data.event_time : 0,
                                     beta_q);
        s = s + trm;
        if (s > 64'hFF_FFFF_FFFF) s = 64'hFF_FFFF_FFFF;
        ig = 0;
        if (in_data.last_event) begin
          ig = (s * 64'(inv_beta_q) + 128) >> 8;
          if (ig > 64'hFFFFFFFF) ig = 64'hFFFFFFFF;
        end
        run_sum <= s[39:0];
        last_t <= in_data.event_time;
        last_exc <= exc[31:0];
        exp_r.excitation = exc[31:0];
        exp_r.integral_valid = in_data.last_event;
        exp_r.integral = ig[31:0];
        exp_r.sequence_end = in_data.last_event;
        feat_q = {feat_q, exp_r};
      end
      if (out_valid && out_ready) begin
        if (feat_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = feat_q.pop_front();
          if (exp_r !== out_data) begin
            $display("%0t: mismatch expected exc=%h iv=%b int=%h end=%b",
                     $time, exp_r.excitation, exp_r.integral_valid,
                     exp_r.integral, exp_r.sequence_end);
            $display("%0t:          actual   exc=%h iv=%b int=%h end=%b",
                     $time, out_data.excitation, out_data.integral_valid,
                     out_data.integral, out_data.sequence_end);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/hawkes_decay_feature_stream_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hawkes_decay_feature_stream_top_test
// Drives event sequences with bursty input and a stalling receiver, writes
// beta and 1/beta between phases, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module hawkes_decay_feature_stream_top_test;
  import hdfs_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_item_t   out_data;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          hold_off = 0;
  logic [31:0] seq_t;

  always #5 clk = ~clk;

  hawkes_decay_feature_stream_top u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hdfs_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_event(logic [31:0] t, logic [31:0] w, logic f, logic l);
    in_valid <= 1;
    in_data <= '{event_time: t, window_end: w, first_event: f, last_event: l};
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t r, logic [15:0] v);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 3'(r) << 2; pwdata <= {16'($urandom_range(0, 65535)), v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic random_sequence();
    int n;
    logic [31:0] w;
    n = $urandom_range(1, 8);
    seq_t = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
    w = seq_t + $urandom_range(0, 32'h0040_0000);
    if ($urandom_range(0, 9) == 0) w = $urandom;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) seq_t = $urandom;
      else seq_t = seq_t + $urandom_range(0, 32'h0002_0000);
      send_event(seq_t, w, k == 0 || $urandom_range(0, 19) == 0,
                 k == n - 1 || $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_event(32'h0, 32'hFFFF_FFFF, 1, 0);
    send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_event(32'h0001_0000, 32'h0, 0, 0);
    send_event(32'h0002_0000, 32'h0010_0000, 0, 1);
    send_event(32'h0003_0000, 32'h0010_0000, 0, 0);
    send_event(32'h0003_0000, 32'h0010_0000, 0, 1);
    send_event(32'h0005_0000, 32'h0008_0000, 1, 1);
    send_event(32'h0, 32'h0, 1, 1);
    drain();
    reg_write(REG_DECAY_RATE, 16'hFFFF);
    reg_write(REG_INV_DECAY, 16'hFFFF);
    send_event(32'h0, 32'hFFFF_FFFF, 1, 0);
    send_event(32'h0000_0001, 32'hFFFF_FFFF, 0, 0);
    send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1);
    drain();
    reg_write(REG_DECAY_RATE, 16'h0);
    reg_write(REG_INV_DECAY, 16'h0);
    send_event(32'h0001_0000, 32'h0009_0000, 1, 0);
    send_event(32'h0004_0000, 32'h0009_0000, 0, 1);
    drain();
    reg_write(REG_DECAY_RATE, 16'd4096);
    reg_write(REG_INV_DECAY, 16'd256);
    hold_off <= 1;
    fork
      begin repeat (400) @(posedge clk); hold_off <= 0; end
      for (int k = 0; k < 12; k++) send_event(32'(k) << 14, 32'h0008_0000, k == 0, k == 11);
    join
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      reg_write(REG_DECAY_RATE, (ph == 0) ? 16'd1 : 16'($urandom_range(0, 65535)));
      reg_write(REG_INV_DECAY, (ph == 1) ? 16'd1 : 16'($urandom_range(0, 65535)));
      for (int s = 0; s < 25; s++) begin
        if ($urandom_range(0, 9) == 0)
          send_event($urandom, $urandom, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        else random_sequence();
      end
    end
    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
